/* rtl/udiv_pkg.sv */
package udiv_pkg;

    localparam int DividendW = 64;
    localparam int DivisorW  = 32;
    localparam int CountW    = $clog2(DividendW);

    localparam logic [CountW-1:0] LastStep = CountW'(DividendW - 1);

    typedef struct packed {
        logic [DividendW-1:0] dividend;
        logic [DivisorW-1:0]  divisor;
    } t_div_in;

    typedef struct packed {
        logic [DividendW-1:0] quotient;
        logic [DivisorW-1:0]  remainder;
        logic                 divide_by_zero;
    } t_div_out;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic [DivisorW-1:0] rem;
        logic                qbit;
    } t_step_res;

endpackage

/* rtl/unsigned_divide_64_by_32.sv */
// Unsigned 64-by-32 divider, restoring long division.
//
// Input channel (i_in_valid / o_in_ready, payload i_in): dividend and divisor.
// Output channel (o_out_valid / i_out_ready, payload o_out): quotient,
// remainder and divide_by_zero flag. A zero divisor gives the flag with
// quotient and remainder zero.
//
// A row of 64 one-bit cells holds the dividend; every step shifts the row by
// one place, the top bit feeds a 33-bit compare-subtract against the divisor,
// and the new quotient bit enters the bottom cell. After 64 steps the row
// holds the quotient; o_out_valid rises once it is in the output register.
// One item is in the cell row at a time; a new one is taken in the cycle the
// previous result moves to the output register, so a steady stream is set by
// the one-bit-per-cycle shift loop, which never holds two items at once.
//
// The output register holds its result while the receiver stalls; the next
// item finishes in the row and waits there until the register frees.
// Reset (synchronous, active low) empties the row and the output register.
module unsigned_divide_64_by_32 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  udiv_pkg::t_div_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output udiv_pkg::t_div_out o_out
);
    import udiv_pkg::*;

    logic                 r_busy;
    logic                 n_busy;
    logic                 r_done;
    logic                 n_done;
    logic [CountW-1:0]    r_count;
    logic [CountW-1:0]    n_count;
    logic [DivisorW-1:0]  r_rem;
    logic [DivisorW-1:0]  n_rem;
    logic [DivisorW-1:0]  r_divisor;
    logic                 r_dbz;
    logic                 r_out_valid;
    t_div_out             r_out;

    logic                 w_accept;
    logic                 w_move;
    t_cell_ctl            w_ctl;
    t_step_res            w_step;
    logic [DividendW-1:0] w_bits;

    assign w_move     = r_done && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy && (!r_done || w_move);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctl.load  = w_accept;
    assign w_ctl.shift = r_busy;

    udiv_step u_step (
        .i_rem     (r_rem),
        .i_bit     (w_bits[DividendW-1]),
        .i_divisor (r_divisor),
        .o_res     (w_step)
    );

    for (genvar k = 0; k < DividendW; k++) begin : g_cell
        if (k == 0) begin : g_first
            udiv_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_load_bit (i_in.dividend[k]),
                .i_shift_in (w_step.qbit),
                .o_bit      (w_bits[k])
            );
        end else begin : g_rest
            udiv_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_load_bit (i_in.dividend[k]),
                .i_shift_in (w_bits[k-1]),
                .o_bit      (w_bits[k])
            );
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = r_done;
        n_count = r_count;
        n_rem   = r_rem;
        if (w_move) begin
            n_done = 1'b0;
        end
        if (w_accept) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_rem   = '0;
        end else if (r_busy) begin
            n_rem   = w_step.rem;
            n_count = r_count + 1'b1;
            if (r_count == LastStep) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (w_accept) begin
            r_divisor <= i_in.divisor;
            r_dbz     <= (i_in.divisor == '0);
        end
        if (w_move) begin
            r_out.quotient       <= r_dbz ? '0 : w_bits;
            r_out.remainder      <= r_dbz ? '0 : r_rem;
            r_out.divide_by_zero <= r_dbz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && r_count == '0)
        else $error("transfer did not start the cell row");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_count == LastStep && !w_accept |=> r_done && !r_busy)
        else $error("last step did not finish the item");

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("row busy while holding a finished result");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.divide_by_zero |->
            o_out.quotient == '0 && o_out.remainder == '0)
        else $error("divide by zero result not cleared");
`endif

endmodule

/* rtl/udiv_cell.sv */
module udiv_cell (
    input  logic                 i_clk,
    input  udiv_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_load_bit,
    input  logic                 i_shift_in,
    output logic                 o_bit
);
    import udiv_pkg::*;

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.load) begin
            n_bit = i_load_bit;
        end else if (i_ctl.shift) begin
            n_bit = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

/* rtl/udiv_step.sv */
module udiv_step (
    input  logic [udiv_pkg::DivisorW-1:0] i_rem,
    input  logic                          i_bit,
    input  logic [udiv_pkg::DivisorW-1:0] i_divisor,
    output udiv_pkg::t_step_res           o_res
);
    import udiv_pkg::*;

    logic [DivisorW:0]   w_partial;
    logic [DivisorW+1:0] w_diff;

    assign w_partial = {i_rem, i_bit};
    assign w_diff    = {1'b0, w_partial} - {2'b00, i_divisor};

    always_comb begin
        o_res.qbit = ~w_diff[DivisorW+1];
        o_res.rem  = o_res.qbit ? w_diff[DivisorW-1:0] : w_partial[DivisorW-1:0];
    end

endmodule
